// ----- hdl/assert_macros.svh -----
// Assertion helpers for the replacement engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a implies b on the next edge.
`define ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
// Check that a implies b on the same edge.
`define ASSERT_NOW(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`endif

// ----- hdl/srrip_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replacement engine package
// Sizes, row types and the sequencer state type.
// ----------------------------------------------------------------------------
package srrip_pkg;
  localparam int NUM_SETS    = 2048;
  localparam int NUM_WAYS    = 16;
  localparam int ADDR_BITS   = 48;
  localparam int SIG_ENTRIES = 32;
  localparam int SET_W       = 11;
  localparam int WAY_W       = 4;
  localparam int SIG_W       = 5;
  localparam int CLR_W       = 12;

  localparam logic OP_VICTIM = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef struct packed {
    logic [1:0]       rrpv;
    logic [SIG_W-1:0] sig;
    logic [1:0]       reuse;
  } line_t;

  typedef line_t [NUM_WAYS-1:0] row_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] addr;
    logic [ADDR_BITS:0]   stride;
    logic [1:0]           conf;
  } det_t;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_AGE, ST_WRITE, ST_OUT
  } state_t;
endpackage

// ----- hdl/srrip_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Replacement state memory
// Line row memory and stream detector memory, with registered read data.
// ----------------------------------------------------------------------------
module srrip_mem (
  input  logic                            clk,
  input  logic [srrip_pkg::SET_W-1:0]     raddr,
  input  logic                            we,
  input  logic [srrip_pkg::SET_W-1:0]     waddr,
  input  srrip_pkg::row_t                 wrow,
  input  srrip_pkg::det_t                 wdet,
  output srrip_pkg::row_t                 rrow,
  output srrip_pkg::det_t                 rdet
);
  srrip_pkg::row_t rows [srrip_pkg::NUM_SETS];
  srrip_pkg::det_t dets [srrip_pkg::NUM_SETS];

  always_ff @(posedge clk) begin
    if (we) begin
      rows[waddr] <= wrow;
      dets[waddr] <= wdet;
    end
    rrow <= rows[raddr];
    rdet <= dets[raddr];
  end
endmodule

// ----- hdl/ship_rrip_replacement_stream_bypass_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHiP-lite SRRIP replacement engine with stream bypass
// Victim selection and line update for a 2048 set by 16 way cache.
// ----------------------------------------------------------------------------
// Usage: a request (op, set_index, way, addr, pc, hit) enters on in_valid
// when in_stall is low. A victim query (op 0) returns victim_way on out_valid
// and holds it while out_stall is high; an update (op 1) returns nothing.
// Each request passes through accept, memory read, aging/update compute and
// write back of the set row; the next request is accepted only once the
// sequencer is back in its idle state.
// A query's result sits in an output register, loaded at its write back,
// so a waiting result does not block new requests.
// The sequencer sets the request rate; the set memory has separate ports.
// The 32 signature counters sit in flip-flops and reset to 1 at once.
// After reset a clearing pass writes every set row, one per cycle;
// in_stall stays high during it.
// A stalled receiver holds the result; a later query then waits after its
// write back, with in_stall high, until the held result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ship_rrip_replacement_stream_bypass_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        op,
  input  logic [10:0] set_index,
  input  logic [3:0]  way,
  input  logic [47:0] addr,
  input  logic [47:0] pc,
  input  logic        hit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  victim_way
);
  srrip_pkg::state_t state, state_next;
  logic [srrip_pkg::CLR_W-1:0] clr;
  logic                   r_op, r_hit;
  logic [srrip_pkg::SET_W-1:0] r_set;
  logic [3:0]             r_way;
  logic [srrip_pkg::ADDR_BITS-1:0] r_addr, r_pc;
  logic [1:0]             sig_ctr [srrip_pkg::SIG_ENTRIES];
  srrip_pkg::row_t        rrow, wrow, row_q;
  srrip_pkg::det_t        rdet, wdet, det_q;
  logic                   we;
  logic [srrip_pkg::SET_W-1:0] waddr;
  logic [3:0]             vway;
  logic [3:0]             vsel_q;
  logic                   res_valid;
  logic                   load;
  logic                   accept;

  assign accept = in_valid && !in_stall;
  assign load   = (state == srrip_pkg::ST_WRITE && r_op == srrip_pkg::OP_VICTIM &&
                   !(res_valid && out_stall)) ||
                  (state == srrip_pkg::ST_OUT && !out_stall);

  srrip_mem u_mem (
    .clk(clk), .raddr(r_set), .we(we), .waddr(waddr),
    .wrow(wrow), .wdet(wdet), .rrow(rrow), .rdet(rdet)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      srrip_pkg::ST_CLEAR: if (clr[srrip_pkg::SET_W]) state_next = srrip_pkg::ST_IDLE;
      srrip_pkg::ST_IDLE:  if (in_valid) state_next = srrip_pkg::ST_READ;
      srrip_pkg::ST_READ:  state_next = srrip_pkg::ST_AGE;
      srrip_pkg::ST_AGE:   state_next = srrip_pkg::ST_WRITE;
      srrip_pkg::ST_WRITE:
        state_next = (r_op == srrip_pkg::OP_VICTIM && res_valid && out_stall) ?
                     srrip_pkg::ST_OUT : srrip_pkg::ST_IDLE;
      srrip_pkg::ST_OUT:   if (!out_stall) state_next = srrip_pkg::ST_IDLE;
      default:             state_next = srrip_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != srrip_pkg::ST_IDLE);
    out_valid = res_valid;
    we        = (state == srrip_pkg::ST_WRITE) ||
                (state == srrip_pkg::ST_CLEAR && !clr[srrip_pkg::SET_W]);
  end

  // Compute modified row and detector from the read data.
  logic [1:0]      top, add;
  logic [srrip_pkg::ADDR_BITS:0] stride;
  logic [1:0]      conf_n;
  logic            streaming;
  logic [srrip_pkg::SIG_W-1:0] nsig, osig;
  srrip_pkg::row_t mrow;
  srrip_pkg::det_t mdet;
  srrip_pkg::line_t ln;
  logic [3:0]      vsel;
  logic            vfound;
  logic [1:0]      octr_n, nctr;
  logic            octr_we;

  always_comb begin
    top = 2'd0;
    for (int w = 0; w < srrip_pkg::NUM_WAYS; w++)
      if (rrow[w].rrpv > top) top = rrow[w].rrpv;
    add  = 2'd3 - top;
    mrow = rrow;
    mdet = rdet;
    octr_we = 1'b0;
    octr_n  = 2'd0;
    vsel = 4'd0;
    vfound = 1'b0;
    stride = {1'b0, r_addr} - {1'b0, rdet.addr};
    conf_n = rdet.conf;
    if (rdet.stride != '0 && stride == rdet.stride) begin
      if (conf_n != 2'd3) conf_n = conf_n + 2'd1;
    end else if (conf_n != 2'd0) begin
      conf_n = conf_n - 2'd1;
    end
    streaming = conf_n[1];
    nsig = r_pc[6:2] ^ r_pc[17:13];
    ln   = rrow[r_way];
    osig = ln.sig;
    nctr = sig_ctr[nsig];
    if (r_op == srrip_pkg::OP_VICTIM) begin
      for (int w = 0; w < srrip_pkg::NUM_WAYS; w++) begin
        mrow[w].rrpv = rrow[w].rrpv + add;
        if (!vfound && mrow[w].rrpv == 2'd3) begin
          vfound = 1'b1;
          vsel = 4'(w);
        end
      end
    end else begin
      mdet.addr   = r_addr;
      mdet.stride = stride;
      mdet.conf   = conf_n;
      if (r_hit) begin
        ln.rrpv = 2'd0;
        if (ln.reuse != 2'd3) ln.reuse = ln.reuse + 2'd1;
        octr_we = (sig_ctr[osig] != 2'd3);
        octr_n  = sig_ctr[osig] + 2'd1;
      end else begin
        octr_we = (ln.reuse == 2'd0) && (sig_ctr[osig] != 2'd0);
        octr_n  = sig_ctr[osig] - 2'd1;
        // New signature counter as seen after the old one is trained.
        if (octr_we && osig == nsig) nctr = octr_n;
        ln.reuse = 2'd0;
        ln.sig   = nsig;
        if (streaming)        ln.rrpv = 2'd3;
        else if (nctr[1])     ln.rrpv = 2'd0;
        else if (nctr == 2'd1) ln.rrpv = 2'd2;
        else                  ln.rrpv = 2'd3;
      end
      mrow[r_way] = ln;
    end
  end

  always_comb begin
    if (state == srrip_pkg::ST_CLEAR) begin
      waddr = clr[srrip_pkg::SET_W-1:0];
      for (int w = 0; w < srrip_pkg::NUM_WAYS; w++)
        wrow[w] = '{rrpv: 2'd3, sig: '0, reuse: 2'd0};
      wdet = '0;
    end else begin
      waddr = r_set;
      wrow  = row_q;
      wdet  = det_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= srrip_pkg::ST_CLEAR;
      clr       <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < srrip_pkg::SIG_ENTRIES; i++) sig_ctr[i] <= 2'd1;
    end else begin
      state <= state_next;
      if (state == srrip_pkg::ST_CLEAR) clr <= clr + 1'b1;
      if (state == srrip_pkg::ST_AGE && octr_we) sig_ctr[osig] <= octr_n;
      if (load) res_valid <= 1'b1;
      else if (!out_stall) res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      r_op <= op; r_set <= set_index; r_way <= way;
      r_addr <= addr; r_pc <= pc; r_hit <= hit;
    end
    if (state == srrip_pkg::ST_AGE) begin
      row_q  <= mrow;
      det_q  <= mdet;
      vsel_q <= vsel;
    end
    if (load) vway <= vsel_q;
  end

  assign victim_way = vway;

  `ASSERT_NOW(a_clear_quiet, state == srrip_pkg::ST_CLEAR, !out_valid && in_stall)
  `ASSERT_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(victim_way))
  `ASSERT_NEXT(a_read_follows, accept, state == srrip_pkg::ST_READ)
endmodule
